>>> hdl/lambert_w0_evaluator_core_defines.svh
// Assertion macros for the checker file.
`ifndef LAMBERT_W0_EVALUATOR_CORE_DEFINES_SVH
`define LAMBERT_W0_EVALUATOR_CORE_DEFINES_SVH

// Checked on every clock edge outside reset
`define LW0_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lw0 check failed");

// Checked on every clock edge, reset included
`define LW0_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("lw0 check failed");

`endif

>>> hdl/lw0_pkg.sv
package lw0_pkg;

    // Number format and field widths
    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 15;
    localparam int X_W       = 32;
    localparam int W_W       = 21;
    localparam int ITER_W    = 4;

    // Datapath widths
    localparam int MAG_W    = 32;                      // multiplier operand magnitude
    localparam int DEN_W    = 33;                      // divider operand magnitude
    localparam int DW       = DEN_W + FRAC_BITS + 1;   // working value width
    localparam int CNT_W    = 6;                       // holds DW - 1
    localparam int LN_ITERS = 26;                      // log2 fraction bits
    localparam int LN_M_W   = 31;                      // mantissa in [1,2), 30 fraction bits
    localparam int LN2_W    = 30;
    localparam int LN_SHIFT = 56 - FRAC_BITS;
    localparam int SQ_W     = 2 * FRAC_BITS + 2;
    localparam int SQ_STEPS = FRAC_BITS + 1;

    // Constants, rounded to nearest from 60 fraction bits
    localparam logic [63:0] E_Q60    = 64'h2B7E151628AED2A6;
    localparam logic [63:0] INVE_Q60 = 64'h05E2D58D8B3BCDF1;
    localparam logic [63:0] E_RND    =
        (E_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic [63:0] INVE_RND =
        (INVE_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);

    localparam logic signed [DW-1:0] E_F        = DW'(E_RND);
    localparam logic signed [DW-1:0] NEG_INVE_F = -DW'(INVE_RND);
    localparam logic signed [DW-1:0] ONE_F      = DW'(64'd1 << FRAC_BITS);
    localparam logic signed [DW-1:0] ULP        = DW'(1);
    localparam logic signed [DW-1:0] B_POS_LO   = ULP;
    localparam logic signed [DW-1:0] B_POS_HI   = DW'(64'd64 << FRAC_BITS);
    localparam logic signed [DW-1:0] B_NEG_LO   = ULP - ONE_F;
    localparam logic signed [DW-1:0] B_NEG_HI   = -ULP;
    localparam logic signed [DW-1:0] W_LO       = -ONE_F;
    localparam logic signed [DW-1:0] W_HI       = DW'(64'd9 << FRAC_BITS);
    localparam logic [LN2_W-1:0]     LN2_Q30    = 30'h2C5C85FE;

    // Configuration registers
    localparam logic [ITER_W-1:0] ITER_LARGE_RST = 4'd5;
    localparam logic [ITER_W-1:0] ITER_SMALL_RST = 4'd9;
    localparam logic CFG_ITER_LARGE = 1'b0;
    localparam logic CFG_ITER_SMALL = 1'b1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MAX1, OP_CLAMPB, OP_OUT, OP_MUL, OP_DIV, OP_LN, OP_SQRT
    } t_op;

    typedef enum logic [2:0] {
        SRC_ZERO, SRC_ONE, SRC_E, SRC_X, SRC_B, SRC_S, SRC_T, SRC_U
    } t_src;

    typedef enum logic [2:0] {
        DST_B, DST_S, DST_T, DST_U, DST_W
    } t_dst;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic go;
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic x_zero;
        logic x_e;
        logic x_ninv;
        logic x_below;
        logic x_neg;
        logic x_lt_e;
        logic x_gt_e;
    } t_sts;

endpackage

>>> hdl/lw0_datapath.sv
module lw0_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lw0_pkg::t_cmd                     i_cmd,
    input  logic signed [lw0_pkg::X_W-1:0]    i_x_value,
    output lw0_pkg::t_sts                     o_sts,
    output logic signed [lw0_pkg::W_W-1:0]    o_w_value
);
    import lw0_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_MUL, PH_DIV, PH_DIV_FIN, PH_SQRT, PH_SQRT_FIN,
        PH_LN_NORM, PH_LN_SQ, PH_LN_UPD, PH_LN_MUL, PH_LN_RND, PH_WB
    } t_phase;

    // Working registers
    logic signed [DW-1:0]    r_x, r_b, r_s, r_t, r_u, r_res;
    logic signed [W_W-1:0]   r_w;
    t_phase                  r_phase;
    t_dst                    r_dst;
    logic                    r_done;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    // Multiplier
    logic [2*MAG_W-1:0]      r_prod;
    // Divider
    logic [DW-1:0]           r_num, r_quo;
    logic [DEN_W-1:0]        r_den, r_rem;
    // Square root
    logic [SQ_W-1:0]         r_sv, r_sr, r_sbit;
    // Logarithm
    logic [DW-1:0]           r_norm;
    logic [CNT_W-1:0]        r_k;
    logic [LN_M_W-1:0]       r_m;
    logic [2*LN_M_W-1:0]     r_sq;
    logic [LN_ITERS-1:0]     r_l;
    logic signed [63:0]      r_lp;

    logic signed [DW-1:0]    a_val, b_val, simple_res, clamp_lo, clamp_hi, mul_res, ln_res;
    logic [DW-1:0]           a_mag, b_mag, div_num, ln_in;
    logic [DEN_W:0]          rem_sh, rem_diff;
    logic                    div_ge;
    logic [SQ_W-1:0]         sq_sum;
    logic                    sq_ge;
    logic [LN_M_W:0]         m_sq;
    logic signed [CNT_W:0]   y_hi;
    logic signed [CNT_W+LN_ITERS:0] y_val;
    logic [63:0]             lp_mag, ln_rm, mul_rm;

    function automatic logic signed [DW-1:0] f_src(
        input t_src sel, input logic signed [DW-1:0] x, input logic signed [DW-1:0] b,
        input logic signed [DW-1:0] s, input logic signed [DW-1:0] t,
        input logic signed [DW-1:0] u);
        unique case (sel)
            SRC_ZERO: return '0;
            SRC_ONE:  return ONE_F;
            SRC_E:    return E_F;
            SRC_X:    return x;
            SRC_B:    return b;
            SRC_S:    return s;
            SRC_T:    return t;
            SRC_U:    return u;
            default:  return '0;
        endcase
    endfunction

    function automatic logic [DW-1:0] f_mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // Operand selection and combinational operations
    always_comb begin
        a_val = f_src(i_cmd.src_a, r_x, r_b, r_s, r_t, r_u);
        b_val = f_src(i_cmd.src_b, r_x, r_b, r_s, r_t, r_u);
        a_mag = f_mag(a_val);
        b_mag = f_mag(b_val);
        clamp_lo = r_x[DW-1] ? B_NEG_LO : B_POS_LO;
        clamp_hi = r_x[DW-1] ? B_NEG_HI : B_POS_HI;
        unique case (i_cmd.op)
            OP_ADD:    simple_res = a_val + b_val;
            OP_SUB:    simple_res = a_val - b_val;
            OP_MAX1:   simple_res = (a_val < ULP) ? ULP : a_val;
            OP_CLAMPB: simple_res = (a_val < clamp_lo) ? clamp_lo :
                                    ((a_val > clamp_hi) ? clamp_hi : a_val);
            OP_OUT:    simple_res = (a_val < W_LO) ? W_LO :
                                    ((a_val > W_HI) ? W_HI : a_val);
            default:   simple_res = a_val;
        endcase
        // Rounded dividend: |a| << F plus half the divisor
        div_num = DW'({a_mag[DEN_W-1:0], FRAC_BITS'(0)}) + DW'(b_mag[DEN_W-1:1]);
        // Logarithm of a non-positive value is taken at one ulp
        ln_in = (a_val <= 0) ? DW'(1) : DW'(a_val);
    end

    // Iteration steps of the shared units
    always_comb begin
        rem_sh   = {r_rem, r_num[DW-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        div_ge   = (rem_sh >= {1'b0, r_den});
        sq_sum   = r_sr + r_sbit;
        sq_ge    = (r_sv >= sq_sum);
        m_sq     = r_sq[2*LN_M_W-1:LN_M_W-1];
        y_hi     = $signed({1'b0, r_k}) - (CNT_W+1)'(FRAC_BITS);
        y_val    = $signed({y_hi, r_l});
        lp_mag   = r_lp[63] ? 64'(-r_lp) : 64'(r_lp);
        ln_rm    = (lp_mag + (64'd1 << (LN_SHIFT - 1))) >> LN_SHIFT;
        ln_res   = r_lp[63] ? -DW'(ln_rm) : DW'(ln_rm);
        mul_rm   = (r_prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mul_res  = r_neg ? -DW'(mul_rm) : DW'(mul_rm);
    end

    // Sequencer of the shared units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load) begin
                r_x <= {{(DW-X_W){i_x_value[X_W-1]}}, i_x_value};
            end
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_cmd.go) begin
                        r_dst <= i_cmd.dst;
                        r_neg <= a_val[DW-1] ^ b_val[DW-1];
                        r_cnt <= '0;
                        unique case (i_cmd.op)
                            OP_MUL: begin
                                r_prod  <= a_mag[MAG_W-1:0] * b_mag[MAG_W-1:0];
                                r_phase <= PH_MUL;
                            end
                            OP_DIV: begin
                                r_num   <= div_num;
                                r_den   <= b_mag[DEN_W-1:0];
                                r_rem   <= '0;
                                r_quo   <= '0;
                                r_phase <= PH_DIV;
                            end
                            OP_SQRT: begin
                                r_sv    <= (a_val <= 0) ? SQ_W'(0)
                                           : {a_mag[FRAC_BITS+1:0], FRAC_BITS'(0)};
                                r_sr    <= '0;
                                r_sbit  <= SQ_W'(1) << (2 * FRAC_BITS);
                                r_phase <= PH_SQRT;
                            end
                            OP_LN: begin
                                r_norm  <= ln_in;
                                r_k     <= CNT_W'(DW - 1);
                                r_phase <= PH_LN_NORM;
                            end
                            default: begin
                                r_res   <= simple_res;
                                r_phase <= PH_WB;
                            end
                        endcase
                    end
                end
                PH_MUL: begin
                    r_res   <= mul_res;
                    r_phase <= PH_WB;
                end
                // Restoring division, one quotient bit a cycle
                PH_DIV: begin
                    r_rem <= div_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    r_num <= r_num << 1;
                    r_quo <= {r_quo[DW-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DW - 1)) begin
                        r_phase <= PH_DIV_FIN;
                    end
                end
                PH_DIV_FIN: begin
                    r_res   <= r_neg ? -$signed(r_quo) : $signed(r_quo);
                    r_phase <= PH_WB;
                end
                // Digit-by-digit square root, one result bit a cycle
                PH_SQRT: begin
                    if (sq_ge) begin
                        r_sv <= r_sv - sq_sum;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                        r_phase <= PH_SQRT_FIN;
                    end
                end
                PH_SQRT_FIN: begin
                    r_res   <= DW'(r_sr);
                    r_phase <= PH_WB;
                end
                // Normalize: leading one to the top, by eight bits or by one
                PH_LN_NORM: begin
                    priority if (r_norm[DW-1]) begin
                        r_m     <= r_norm[DW-1 -: LN_M_W];
                        r_l     <= '0;
                        r_phase <= PH_LN_SQ;
                    end else if (r_norm[DW-1 -: 8] == 8'd0) begin
                        r_norm <= r_norm << 8;
                        r_k    <= r_k - CNT_W'(8);
                    end else begin
                        r_norm <= r_norm << 1;
                        r_k    <= r_k - 1'b1;
                    end
                end
                // log2 fraction by repeated squaring
                PH_LN_SQ: begin
                    r_sq    <= r_m * r_m;
                    r_phase <= PH_LN_UPD;
                end
                PH_LN_UPD: begin
                    r_l   <= {r_l[LN_ITERS-2:0], m_sq[LN_M_W]};
                    r_m   <= m_sq[LN_M_W] ? m_sq[LN_M_W:1] : m_sq[LN_M_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    r_phase <= (r_cnt == CNT_W'(LN_ITERS - 1)) ? PH_LN_MUL : PH_LN_SQ;
                end
                PH_LN_MUL: begin
                    r_lp    <= y_val * $signed({1'b0, LN2_Q30});
                    r_phase <= PH_LN_RND;
                end
                PH_LN_RND: begin
                    r_res   <= ln_res;
                    r_phase <= PH_WB;
                end
                PH_WB: begin
                    unique case (r_dst)
                        DST_B:   r_b <= r_res;
                        DST_S:   r_s <= r_res;
                        DST_T:   r_t <= r_res;
                        DST_U:   r_u <= r_res;
                        DST_W:   r_w <= r_res[W_W-1:0];
                        default: r_b <= r_res;
                    endcase
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    // Status toward the controller
    assign o_sts = '{
        done:    r_done,
        x_zero:  (r_x == '0),
        x_e:     (r_x == E_F),
        x_ninv:  (r_x == NEG_INVE_F),
        x_below: (r_x < NEG_INVE_F),
        x_neg:   r_x[DW-1],
        x_lt_e:  (r_x < E_F),
        x_gt_e:  (r_x > E_F)
    };
    assign o_w_value = r_w;

endmodule

>>> hdl/lw0_controller.sv
module lw0_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_out_of_domain,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [lw0_pkg::ITER_W-1:0]    i_cfg_data,
    output lw0_pkg::t_cmd                 o_cmd,
    input  lw0_pkg::t_sts                 i_sts
);
    import lw0_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLASS,
        ST_SP_ZERO, ST_SP_E, ST_SP_NINV, ST_SP_BAD,
        ST_N_EX, ST_N_T, ST_N_TMAX, ST_N_SQRT, ST_N_ONEPS, ST_N_LN,
        ST_N_NUM, ST_N_DEN, ST_N_DENMAX, ST_N_DIV,
        ST_PS_DIV, ST_PL_LN1, ST_PL_LN2, ST_PL_SUB,
        ST_CLAMP0,
        ST_L_ONEPB, ST_L_R, ST_L_XB, ST_L_LN, ST_L_F, ST_L_MUL, ST_L_CLAMP,
        ST_FINAL
    } t_state;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        t_dst dst;
    } t_uop;

    t_state            r_state;
    t_uop              r_uop;
    logic              r_go, r_busy, r_bad, r_out_valid, r_out_bad;
    logic [ITER_W-1:0] r_large, r_small, r_cnt;
    logic [ITER_W-1:0] n_steps, sel_steps;
    logic              accept;

    // Operation issued in each state
    function automatic t_uop f_uop(input t_state st);
        unique case (st)
            ST_SP_ZERO:  return '{OP_ADD,    SRC_ZERO, SRC_ZERO, DST_B};
            ST_SP_E:     return '{OP_ADD,    SRC_ONE,  SRC_ZERO, DST_B};
            ST_SP_NINV:  return '{OP_SUB,    SRC_ZERO, SRC_ONE,  DST_B};
            ST_SP_BAD:   return '{OP_ADD,    SRC_ZERO, SRC_ZERO, DST_B};
            ST_N_EX:     return '{OP_MUL,    SRC_E,    SRC_X,    DST_T};
            ST_N_T:      return '{OP_ADD,    SRC_ONE,  SRC_T,    DST_U};
            ST_N_TMAX:   return '{OP_MAX1,   SRC_U,    SRC_ZERO, DST_U};
            ST_N_SQRT:   return '{OP_SQRT,   SRC_U,    SRC_ZERO, DST_S};
            ST_N_ONEPS:  return '{OP_ADD,    SRC_ONE,  SRC_S,    DST_U};
            ST_N_LN:     return '{OP_LN,     SRC_U,    SRC_ZERO, DST_B};
            ST_N_NUM:    return '{OP_MUL,    SRC_T,    SRC_B,    DST_B};
            ST_N_DEN:    return '{OP_MUL,    SRC_S,    SRC_U,    DST_U};
            ST_N_DENMAX: return '{OP_MAX1,   SRC_U,    SRC_ZERO, DST_U};
            ST_N_DIV:    return '{OP_DIV,    SRC_B,    SRC_U,    DST_B};
            ST_PS_DIV:   return '{OP_DIV,    SRC_X,    SRC_E,    DST_B};
            ST_PL_LN1:   return '{OP_LN,     SRC_X,    SRC_ZERO, DST_T};
            ST_PL_LN2:   return '{OP_LN,     SRC_T,    SRC_ZERO, DST_U};
            ST_PL_SUB:   return '{OP_SUB,    SRC_T,    SRC_U,    DST_B};
            ST_CLAMP0:   return '{OP_CLAMPB, SRC_B,    SRC_ZERO, DST_B};
            ST_L_ONEPB:  return '{OP_ADD,    SRC_ONE,  SRC_B,    DST_T};
            ST_L_R:      return '{OP_DIV,    SRC_B,    SRC_T,    DST_T};
            ST_L_XB:     return '{OP_DIV,    SRC_X,    SRC_B,    DST_U};
            ST_L_LN:     return '{OP_LN,     SRC_U,    SRC_ZERO, DST_U};
            ST_L_F:      return '{OP_ADD,    SRC_ONE,  SRC_U,    DST_U};
            ST_L_MUL:    return '{OP_MUL,    SRC_T,    SRC_U,    DST_B};
            ST_L_CLAMP:  return '{OP_CLAMPB, SRC_B,    SRC_ZERO, DST_B};
            ST_FINAL:    return '{OP_OUT,    SRC_B,    SRC_ZERO, DST_W};
            default:     return '{OP_ADD,    SRC_ZERO, SRC_ZERO, DST_B};
        endcase
    endfunction

    // Successor of each straight-line state
    function automatic t_state f_next(input t_state st);
        unique case (st)
            ST_N_EX:     return ST_N_T;
            ST_N_T:      return ST_N_TMAX;
            ST_N_TMAX:   return ST_N_SQRT;
            ST_N_SQRT:   return ST_N_ONEPS;
            ST_N_ONEPS:  return ST_N_LN;
            ST_N_LN:     return ST_N_NUM;
            ST_N_NUM:    return ST_N_DEN;
            ST_N_DEN:    return ST_N_DENMAX;
            ST_N_DENMAX: return ST_N_DIV;
            ST_N_DIV:    return ST_CLAMP0;
            ST_PS_DIV:   return ST_CLAMP0;
            ST_PL_LN1:   return ST_PL_LN2;
            ST_PL_LN2:   return ST_PL_SUB;
            ST_PL_SUB:   return ST_CLAMP0;
            ST_L_ONEPB:  return ST_L_R;
            ST_L_R:      return ST_L_XB;
            ST_L_XB:     return ST_L_LN;
            ST_L_LN:     return ST_L_F;
            ST_L_F:      return ST_L_MUL;
            ST_L_MUL:    return ST_L_CLAMP;
            default:     return ST_FINAL;
        endcase
    endfunction

    // Step count for this request
    always_comb begin
        sel_steps = i_sts.x_gt_e ? r_large : r_small;
        n_steps   = (int'(sel_steps) > MAX_STEPS) ? ITER_W'(MAX_STEPS) : sel_steps;
    end

    assign accept = (r_state == ST_IDLE) && i_in_valid;

    // State machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_busy      <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_bad   <= 1'b0;
            r_cnt       <= '0;
            r_large     <= ITER_LARGE_RST;
            r_small     <= ITER_SMALL_RST;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ITER_LARGE: r_large <= i_cfg_data;
                    CFG_ITER_SMALL: r_small <= i_cfg_data;
                    default:        r_small <= i_cfg_data;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    r_bad <= 1'b0;
                    r_cnt <= n_steps;
                    priority if (i_sts.x_zero) begin
                        r_state <= ST_SP_ZERO;
                    end else if (i_sts.x_e) begin
                        r_state <= ST_SP_E;
                    end else if (i_sts.x_ninv) begin
                        r_state <= ST_SP_NINV;
                    end else if (i_sts.x_below) begin
                        r_bad   <= 1'b1;
                        r_state <= ST_SP_BAD;
                    end else if (i_sts.x_neg) begin
                        r_state <= ST_N_EX;
                    end else if (i_sts.x_lt_e) begin
                        r_state <= ST_PS_DIV;
                    end else begin
                        r_state <= ST_PL_LN1;
                    end
                end
                // Result goes out only once the output register is free
                ST_FINAL: begin
                    if (!r_busy) begin
                        if (!r_out_valid) begin
                            r_go   <= 1'b1;
                            r_uop  <= f_uop(r_state);
                            r_busy <= 1'b1;
                        end
                    end else if (i_sts.done) begin
                        r_busy      <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    if (!r_busy) begin
                        r_go   <= 1'b1;
                        r_uop  <= f_uop(r_state);
                        r_busy <= 1'b1;
                    end else if (i_sts.done) begin
                        r_busy <= 1'b0;
                        priority if (r_state == ST_CLAMP0) begin
                            r_state <= (r_cnt == '0) ? ST_FINAL : ST_L_ONEPB;
                        end else if (r_state == ST_L_CLAMP) begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= (r_cnt == ITER_W'(1)) ? ST_FINAL : ST_L_ONEPB;
                        end else begin
                            r_state <= f_next(r_state);
                        end
                    end
                end
            endcase
        end
    end

    assign o_cmd = '{
        load:  accept,
        go:    r_go,
        op:    r_uop.op,
        src_a: r_uop.a,
        src_b: r_uop.b,
        dst:   r_uop.dst
    };
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_of_domain = r_out_bad;
    assign o_cfg_ready     = 1'b1;

endmodule

>>> hdl/lambert_w0_evaluator_core.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_stall     i_x_value (Q16.16, signed)
// out       output     o_out_valid / i_out_stall   o_w_value, o_out_of_domain
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request at a time. Special inputs (zero, e, -1/e, below domain) set their
// result directly and go to the output step. Other inputs compute a start value
// and then run refinement steps; each step holds two divisions by the
// one-bit-a-cycle divider and a logarithm with its squaring loop.
// Reset is synchronous, active low, and restores both step counts.
// A finished result waits in the output register while the next request is taken.
module lambert_w0_evaluator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [lw0_pkg::X_W-1:0]    i_x_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [lw0_pkg::W_W-1:0]    o_w_value,
    output logic                              o_out_of_domain,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [lw0_pkg::ITER_W-1:0]        i_cfg_data
);
    import lw0_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing and handshakes
    lw0_controller u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_of_domain (o_out_of_domain),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    // Arithmetic units and value registers
    lw0_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_x_value (i_x_value),
        .o_sts     (sts),
        .o_w_value (o_w_value)
    );

endmodule

>>> hdl/lw0_checker.sv
`include "lambert_w0_evaluator_core_defines.svh"

module lw0_port_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [lw0_pkg::W_W-1:0]    o_w_value,
    input logic                              o_out_of_domain
);

    // Stalled result holds
    `LW0_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_w_value))
    // Out of domain always comes with a zero result
    `LW0_ASSERT(a_bad_zero, o_out_valid && o_out_of_domain |-> o_w_value == 0)
    // Result stays within [-1.0, 9.0]
    `LW0_ASSERT(a_w_range, o_out_valid |-> o_w_value >= -65536 && o_w_value <= 589824)
    // Accepted request occupies the block
    `LW0_ASSERT(a_busy, i_in_valid && !o_in_stall |=> o_in_stall)
    // No result straight out of reset
    `LW0_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid)

endmodule

bind lambert_w0_evaluator_core lw0_port_checker u_lw0_checker (.*);
